@@ src/buddy_allocator_defines.svh @@
// assertion macros for the buddy allocator
`ifndef BUDDY_ALLOCATOR_DEFINES_SVH
`define BUDDY_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BA_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("buddy allocator check failed");
`define BA_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("buddy allocator check failed");
`else
`define BA_ASSERT_IMP(label, clk, rst_n, a, c)
`define BA_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

@@ src/ba_pkg.sv @@
// shared types and constants of the buddy allocator
`default_nettype none
package ba_pkg;
  localparam int TOTAL_UNITS = 1024;
  localparam int LEVELS = $clog2(TOTAL_UNITS);
  localparam int NODE_COUNT = 2 * TOTAL_UNITS - 1;
  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int SIZE_W = LEVELS + 1;
  localparam int UNIT_W = LEVELS;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // classified job handed from front to back
  typedef struct packed {
    logic              is_free;
    logic              reject;
    logic [SIZE_W-1:0] want;
    logic [UNIT_W-1:0] unit;
  } job_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [UNIT_W-1:0] grant_unit;
  } res_t;
endpackage
`default_nettype wire

@@ src/buddy_allocator.sv @@
// Binary buddy allocator, top level.
// Input: pulse start with cmd/request_bytes/free_unit while busy is low;
// the item is taken at that edge. cmd 0 allocates request_bytes, cmd 1
// frees the block holding free_unit.
// Result: out_valid is high for exactly one cycle with out_status and
// out_grant_unit; the receiver cannot stall, so the result is never held.
// Config: cfg_we with cfg_wdata writes unit_bytes (reset 64); write only
// while the block is idle.
// Flow: an allocate runs the bit-serial division, then walks the tree down,
// reading both children per level, and back up, rewriting each parent; a
// free climbs to the first node that reads zero, then merges on the way up.
// The tree lives in one single-port ram, one access a cycle, which sets
// the walk time. One item at a time; busy stays high until its result.
// After reset a clearing pass loads every node with its subtree size; busy
// is high during it.
`default_nettype none
`include "buddy_allocator_defines.svh"
module buddy_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_request_bytes,
  input  wire logic [9:0]  in_free_unit,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [9:0]       out_grant_unit,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata
);
  logic [16:0]  unit_bytes_r;
  logic         fr_busy, job_valid, job_ready, init_done, res_valid;
  logic         pend_r, pend_nxt;
  logic         res_err;
  ba_pkg::job_t job;
  ba_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_bytes_r <= 17'd64; pend_r <= 1'b0;
    end else begin
      if (cfg_we) unit_bytes_r <= cfg_wdata;
      pend_r <= pend_nxt;
    end
  end

  // one item in flight from acceptance to its result transfer
  always_comb begin
    pend_nxt = pend_r;
    if (start && !busy) pend_nxt = 1'b1;
    else if (res_valid) pend_nxt = 1'b0;
  end

  assign busy = pend_r || fr_busy || !init_done;

  ba_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start && !busy), .fr_busy(fr_busy),
    .cmd(in_cmd), .request_bytes(in_request_bytes), .free_unit(in_free_unit),
    .unit_bytes(unit_bytes_r), .job_valid(job_valid), .job_ready(job_ready),
    .job(job)
  );

  ba_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
    .job(job), .init_done(init_done), .res_valid(res_valid), .res(res)
  );

  assign out_valid = res_valid;
  assign out_status = res.status;
  assign out_grant_unit = res.grant_unit;
  assign res_err = out_valid && (out_status != ba_pkg::ST_OK);

  `BA_ASSERT_IMP(a_res_pending, clk, rst_n, out_valid, pend_r)
  `BA_ASSERT_NXT(a_res_single, clk, rst_n, out_valid, !out_valid)
  `BA_ASSERT_IMP(a_unit_zero, clk, rst_n, res_err, out_grant_unit == 10'd0)
endmodule
`default_nettype wire

@@ src/ba_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module ba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ src/ba_front.sv @@
// front end: converts bytes to units by restoring division, classifies items
`default_nettype none
module ba_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          fr_busy,
  input  wire logic                     cmd,
  input  wire logic [31:0]              request_bytes,
  input  wire logic [ba_pkg::UNIT_W-1:0] free_unit,
  input  wire logic [16:0]              unit_bytes,
  output logic                          job_valid,
  input  wire logic                     job_ready,
  output ba_pkg::job_t                  job
);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_OUT  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        free_r, free_nxt;
  logic [ba_pkg::UNIT_W-1:0] unit_r, unit_nxt;
  logic [17:0] trial;
  logic [32:0] units;
  logic [ba_pkg::SIZE_W-1:0] want;
  logic        big;

  always_comb begin
    trial = {rem_r, quo_r[31]} - {1'b0, div_r};
    units = {1'b0, quo_r} + {32'd0, (rem_r != 17'd0)};
    if (units == 33'd0) units = 33'd1;
    big = units > 33'(ba_pkg::TOTAL_UNITS);
    want = '0;
    for (int i = ba_pkg::LEVELS; i >= 0; i--) begin
      if (units <= (33'd1 << i)) want = ba_pkg::SIZE_W'(1) << i;
    end
  end

  always_comb begin
    state_nxt = state_r; quo_nxt = quo_r; rem_nxt = rem_r; div_nxt = div_r;
    cnt_nxt = cnt_r; free_nxt = free_r; unit_nxt = unit_r;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          free_nxt = (cmd == ba_pkg::CMD_FREE);
          unit_nxt = free_unit;
          quo_nxt = request_bytes;
          rem_nxt = '0;
          div_nxt = (unit_bytes == 17'd0) ? 17'd1 : unit_bytes;
          cnt_nxt = '0;
          state_nxt = (cmd == ba_pkg::CMD_FREE) ? F_OUT : F_DIV;
        end
      end
      F_DIV: begin
        if (!trial[17]) begin
          rem_nxt = trial[16:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[15:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) state_nxt = F_OUT;
      end
      F_OUT: if (job_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else state_r <= state_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; div_r <= div_nxt;
    cnt_r <= cnt_nxt; free_r <= free_nxt; unit_r <= unit_nxt;
  end

  assign fr_busy = (state_r != F_IDLE);
  assign job_valid = (state_r == F_OUT);
  always_comb begin
    job.is_free = free_r;
    job.reject = !free_r && big;
    job.want = want;
    job.unit = unit_r;
  end
endmodule
`default_nettype wire

@@ src/ba_back.sv @@
// back end: walks the largest-free tree in ram, one access per cycle
`default_nettype none
module ba_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         job_valid,
  output logic              job_ready,
  input  wire ba_pkg::job_t job,
  output logic              init_done,
  output logic              res_valid,
  output ba_pkg::res_t      res
);
  localparam int NW = ba_pkg::NODE_W;
  localparam int SW = ba_pkg::SIZE_W;
  localparam logic [3:0] B_INIT = 4'd0, B_IDLE = 4'd1, B_ROOT = 4'd2,
                         B_RDL = 4'd3, B_RDR = 4'd4, B_PICK = 4'd5,
                         B_UPR = 4'd6, B_UPW = 4'd7, B_FRD = 4'd8,
                         B_FCHK = 4'd9, B_DONE = 4'd10, B_URL = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [NW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [SW-1:0] want_r, want_nxt;
  logic [SW-1:0] lval_r, lval_nxt;
  logic          free_r, free_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [ba_pkg::UNIT_W-1:0] first_r, first_nxt;
  logic [NW-1:0] init_r, init_nxt;
  logic [SW-1:0] init_sz_r, init_sz_nxt;

  logic          we;
  logic [NW-1:0] addr;
  logic [SW-1:0] wdata, rdata;
  logic [NW-1:0] par, lo, hi;
  logic [NW:0]   pos;
  logic [SW:0]   sum;

  ba_ram #(.WIDTH(SW), .DEPTH(ba_pkg::NODE_COUNT)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    par = (idx_r - NW'(1)) >> 1;
    pos = {1'b0, idx_r} + (NW+1)'(1);
    sum = {1'b0, lval_r} + {1'b0, rdata};
    lo = '0; hi = '0;
    state_nxt = state_r; idx_nxt = idx_r; size_nxt = size_r; want_nxt = want_r;
    lval_nxt = lval_r; free_nxt = free_r; st_nxt = st_r; first_nxt = first_r;
    init_nxt = init_r; init_sz_nxt = init_sz_r;
    we = 1'b0; addr = idx_r; wdata = '0;
    job_ready = 1'b0; res_valid = 1'b0;
    case (state_r)
      B_INIT: begin
        // clearing pass: node i holds its subtree size
        we = 1'b1; addr = init_r;
        if (((init_r + NW'(1)) & init_r) == '0 && init_r != '0)
          init_sz_nxt = init_sz_r >> 1;
        wdata = (((init_r + NW'(1)) & init_r) == '0 && init_r != '0) ?
                (init_sz_r >> 1) : init_sz_r;
        init_nxt = init_r + NW'(1);
        if (init_r == NW'(ba_pkg::NODE_COUNT - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          free_nxt = job.is_free; want_nxt = job.want; first_nxt = '0;
          if (job.is_free) begin
            idx_nxt = NW'({1'b0, job.unit}) + NW'(ba_pkg::TOTAL_UNITS - 1);
            size_nxt = SW'(1);
            addr = NW'({1'b0, job.unit}) + NW'(ba_pkg::TOTAL_UNITS - 1);
            state_nxt = B_FCHK;
          end else if (job.reject) begin
            st_nxt = ba_pkg::ST_NOSPACE; state_nxt = B_DONE;
          end else begin
            idx_nxt = '0; size_nxt = SW'(ba_pkg::TOTAL_UNITS);
            addr = '0; state_nxt = B_ROOT;
          end
        end
      end
      B_ROOT: begin
        if (rdata < want_r) begin
          st_nxt = ba_pkg::ST_NOSPACE; state_nxt = B_DONE;
        end else if (size_r == want_r) begin
          state_nxt = B_PICK;
        end else begin
          addr = (idx_r << 1) + NW'(1); state_nxt = B_RDL;
        end
      end
      B_RDL: begin
        lval_nxt = rdata;
        addr = (idx_r << 1) + NW'(2); state_nxt = B_RDR;
      end
      B_RDR: begin
        lo = (idx_r << 1) + NW'(1); hi = (idx_r << 1) + NW'(2);
        if (lval_r > rdata) begin
          idx_nxt = (rdata >= want_r) ? hi : lo;
        end else begin
          idx_nxt = (lval_r >= want_r) ? lo : hi;
        end
        size_nxt = size_r >> 1;
        state_nxt = B_PICK;
      end
      B_PICK: begin
        if (size_r != want_r) begin
          addr = (idx_r << 1) + NW'(1); state_nxt = B_RDL;
        end else begin
          we = 1'b1; wdata = '0;
          first_nxt = ba_pkg::UNIT_W'(pos * (NW+1)'(size_r) -
                                      (NW+1)'(ba_pkg::TOTAL_UNITS));
          st_nxt = ba_pkg::ST_OK;
          state_nxt = (idx_r == '0) ? B_DONE : B_URL;
        end
      end
      B_FCHK: begin
        if (rdata == '0) begin
          we = 1'b1; wdata = size_r; st_nxt = ba_pkg::ST_OK;
          state_nxt = (idx_r == '0) ? B_DONE : B_URL;
        end else if (idx_r == '0) begin
          st_nxt = ba_pkg::ST_BADFREE; state_nxt = B_DONE;
        end else begin
          idx_nxt = par; size_nxt = size_r << 1;
          addr = par; state_nxt = B_FRD;
        end
      end
      B_FRD: state_nxt = B_FCHK;
      B_URL: begin
        // ascend: read left child of parent
        idx_nxt = par; addr = (par << 1) + NW'(1);
        if (free_r) size_nxt = size_r << 1;
        state_nxt = B_UPR;
      end
      B_UPR: begin
        lval_nxt = rdata; addr = (idx_r << 1) + NW'(2); state_nxt = B_UPW;
      end
      B_UPW: begin
        we = 1'b1;
        if (free_r && sum == {1'b0, size_r}) wdata = size_r;
        else wdata = (lval_r > rdata) ? lval_r : rdata;
        state_nxt = (idx_r == '0) ? B_DONE : B_URL;
      end
      B_DONE: begin
        res_valid = 1'b1; state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
    res.status = st_r;
    res.grant_unit = first_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_INIT; init_r <= '0; init_sz_r <= SW'(ba_pkg::TOTAL_UNITS);
    end else begin
      state_r <= state_nxt; init_r <= init_nxt; init_sz_r <= init_sz_nxt;
    end
    idx_r <= idx_nxt; size_r <= size_nxt; want_r <= want_nxt; lval_r <= lval_nxt;
    free_r <= free_nxt; st_r <= st_nxt; first_r <= first_nxt;
  end

  assign init_done = (state_r != B_INIT);
endmodule
`default_nettype wire

@@ sim/ba_checker.sv @@
// checker for the buddy allocator: tracks the free-size tree and compares each result
module ba_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_request_bytes,
  input  wire logic [9:0]  in_free_unit,
  input  wire logic        out_valid,
  input  wire logic [1:0]  out_status,
  input  wire logic [9:0]  out_grant_unit,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ba_pkg::SIZE_W-1:0] free_size [ba_pkg::NODE_COUNT];
  logic [16:0]               unit_bytes;
  ba_pkg::res_t              grant_queue [$];

  assign pending = grant_queue.size();

  task automatic clear_tree();
    int sz;
    sz = 2 * ba_pkg::TOTAL_UNITS;
    for (int i = 0; i < ba_pkg::NODE_COUNT; i++) begin
      if (((i + 1) & i) == 0) sz = sz >> 1;
      free_size[i] = ba_pkg::SIZE_W'(sz);
    end
  endtask

  task automatic predict_alloc(input logic [31:0] req, output ba_pkg::res_t r);
    longint unsigned ub, units;
    int want, nsz, idx, lo, hi, t;
    r.status = ba_pkg::ST_NOSPACE;
    r.grant_unit = '0;
    ub = (unit_bytes == 0) ? 1 : unit_bytes;
    units = req / ub + ((req % ub) != 0 ? 1 : 0);
    if (units == 0) units = 1;
    if (units > ba_pkg::TOTAL_UNITS || free_size[0] < units) return;
    want = 1;
    while (want < units) want = want << 1;
    if (free_size[0] < want) return;
    idx = 0;
    for (nsz = ba_pkg::TOTAL_UNITS; nsz != want; nsz = nsz >> 1) begin
      lo = 2 * idx + 1;
      hi = 2 * idx + 2;
      if (free_size[lo] > free_size[hi]) begin
        t = lo; lo = hi; hi = t;
      end
      idx = (free_size[lo] >= want) ? lo : hi;
    end
    free_size[idx] = '0;
    r.status = ba_pkg::ST_OK;
    r.grant_unit = ba_pkg::UNIT_W'((idx + 1) * nsz - ba_pkg::TOTAL_UNITS);
    while (idx != 0) begin
      idx = (idx - 1) >> 1;
      free_size[idx] = (free_size[2*idx+1] > free_size[2*idx+2]) ?
                       free_size[2*idx+1] : free_size[2*idx+2];
    end
  endtask

  task automatic predict_free(input logic [9:0] unit, output ba_pkg::res_t r);
    int nsz, idx, l, rr;
    r.status = ba_pkg::ST_BADFREE;
    r.grant_unit = '0;
    nsz = 1;
    idx = unit + ba_pkg::TOTAL_UNITS - 1;
    while (free_size[idx] != 0) begin
      if (idx == 0) return;
      nsz = nsz << 1;
      idx = (idx - 1) >> 1;
    end
    free_size[idx] = ba_pkg::SIZE_W'(nsz);
    // merge buddies on the way up
    while (idx != 0) begin
      idx = (idx - 1) >> 1;
      nsz = nsz << 1;
      l = free_size[2*idx+1];
      rr = free_size[2*idx+2];
      free_size[idx] = ba_pkg::SIZE_W'((l + rr == nsz) ? nsz : ((l > rr) ? l : rr));
    end
    r.status = ba_pkg::ST_OK;
  endtask

  always @(posedge clk) begin
    ba_pkg::res_t r, want_r;
    if (!rst_n) begin
      clear_tree();
      unit_bytes <= 17'd64;
      grant_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) unit_bytes <= cfg_wdata;
      if (start && !busy) begin
        if (in_cmd == ba_pkg::CMD_ALLOC) predict_alloc(in_request_bytes, r);
        else predict_free(in_free_unit, r);
        grant_queue.push_back(r);
      end
      if (out_valid) begin
        if (grant_queue.size() == 0) begin
          $display("%0t: result with none expected: status %0d unit %0d",
                   $time, out_status, out_grant_unit);
          fail_count <= fail_count + 1;
        end else begin
          want_r = grant_queue.pop_front();
          if (out_status !== want_r.status || out_grant_unit !== want_r.grant_unit) begin
            $display("%0t: expected status %0d unit %0d, got status %0d unit %0d",
                     $time, want_r.status, want_r.grant_unit, out_status, out_grant_unit);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ sim/tb_buddy_allocator.sv @@
// testbench top for the buddy allocator: stimulus, clock, reset and verdict
module tb_buddy_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 255;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = ba_pkg::CMD_ALLOC;
  logic [31:0] in_request_bytes = '0;
  logic [9:0]  in_free_unit = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [9:0]  out_grant_unit;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic [16:0] cur_unit_bytes = 17'd64;
  int          fail_count, pending, cycles = 0;
  bit          allow_gaps = 1'b1;

  always #5 clk = ~clk;

  buddy_allocator u_top (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_request_bytes, .in_free_unit,
    .out_valid, .out_status, .out_grant_unit, .cfg_we, .cfg_wdata
  );

  ba_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_request_bytes, .in_free_unit,
    .out_valid, .out_status, .out_grant_unit, .cfg_we, .cfg_wdata,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one transfer: start is raised at a falling edge where busy is already low
  task automatic issue(input logic cmd, input logic [31:0] bytes, input logic [9:0] unit);
    if (allow_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1'b1;
    in_cmd <= cmd;
    in_request_bytes <= bytes;
    in_free_unit <= unit;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0 || busy) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_unit(input logic [16:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    cur_unit_bytes <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    longint unsigned ub, units, bytes;
    int pick;
    pick = $urandom_range(0, 99);
    ub = (cur_unit_bytes == 0) ? 1 : cur_unit_bytes;
    if (pick < 48) begin
      units = $urandom_range(1, 1 << $urandom_range(0, 5));
      if ($urandom_range(0, 15) == 0) units = $urandom_range(1, 1024);
      bytes = units * ub - $urandom_range(0, int'(ub - 1));
      if ($urandom_range(0, 9) == 0) bytes = $urandom_range(0, 3);
      if (bytes > 32'hFFFF_FFFF) bytes = 32'hFFFF_FFFF;
      issue(ba_pkg::CMD_ALLOC, 32'(bytes), '0);
    end else if (pick < 52) begin
      issue(ba_pkg::CMD_ALLOC, $urandom, '0);
    end else begin
      issue(ba_pkg::CMD_FREE, $urandom, 10'($urandom_range(0, 1023)));
    end
  endtask

  initial begin
    logic [16:0] unit_set [6];
    unit_set = '{17'd64, 17'd1, 17'd0, 17'd65536, 17'h1FFFF, 17'd0};
    unit_set[5] = 17'($urandom_range(2, 5000));
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, whole-pool grant, frees inside and outside blocks
    issue(ba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, '0);
    issue(ba_pkg::CMD_ALLOC, 32'd65536, '0);
    issue(ba_pkg::CMD_ALLOC, 32'd1, '0);
    issue(ba_pkg::CMD_FREE, '0, 10'd5);
    issue(ba_pkg::CMD_FREE, '0, 10'd5);
    issue(ba_pkg::CMD_FREE, '0, 10'd1023);
    issue(ba_pkg::CMD_ALLOC, 32'd0, '0);
    issue(ba_pkg::CMD_ALLOC, 32'd64, '0);
    issue(ba_pkg::CMD_ALLOC, 32'd65, '0);
    issue(ba_pkg::CMD_ALLOC, 32'd3000, '0);
    issue(ba_pkg::CMD_ALLOC, 32'd65537, '0);
    issue(ba_pkg::CMD_FREE, '0, 10'd0);
    issue(ba_pkg::CMD_FREE, '0, 10'd0);
    issue(ba_pkg::CMD_FREE, '0, 10'd1023);
    issue(ba_pkg::CMD_FREE, '0, 10'd4);
    issue(ba_pkg::CMD_FREE, '0, 10'd2);
    issue(ba_pkg::CMD_FREE, '0, 10'd512);
    drain();

    foreach (unit_set[p]) begin
      write_unit(unit_set[p]);
      if (p == 5) allow_gaps = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_item();
        if (i == PHASE_ITEMS / 2 && p == 2) drain();
      end
    end

    drain();
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/ba_pkg.sv
src/ba_ram.sv
src/ba_front.sv
src/ba_back.sv
src/buddy_allocator.sv
sim/ba_checker.sv
sim/tb_buddy_allocator.sv
